FILE: rtl/core/gpr_instruction_executor_macros.svh
// Assertion macros for the instruction executor.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef GPR_INSTRUCTION_EXECUTOR_MACROS_SVH
`define GPR_INSTRUCTION_EXECUTOR_MACROS_SVH

`ifndef SYNTHESIS
`define GPRE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define GPRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GPRE_ASSERT_NEVER(label, cond, msg)
`define GPRE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/core/gpre_pkg.sv
package gpre_pkg;

  // Data memory geometry.
  localparam int DATA_BYTES = 4096;
  localparam int DAW = $clog2(DATA_BYTES);
  localparam logic [31:0] DMEM_SPAN = 32'(DATA_BYTES);
  localparam logic [31:0] DATA_BASE = 32'h4000_0000;

  // Register file geometry.
  localparam int NREGS = 32;
  localparam int RAW = 5;

  // Stream widths.
  localparam int IN_TDATA_W = 56;
  localparam int OUT_TDATA_W = 96;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);

  // Opcodes.
  localparam logic [3:0] OP_ADDI    = 4'd0;
  localparam logic [3:0] OP_B       = 4'd1;
  localparam logic [3:0] OP_BEQZ    = 4'd2;
  localparam logic [3:0] OP_BGE     = 4'd3;
  localparam logic [3:0] OP_BNE     = 4'd4;
  localparam logic [3:0] OP_LA      = 4'd5;
  localparam logic [3:0] OP_LB      = 4'd6;
  localparam logic [3:0] OP_LI      = 4'd7;
  localparam logic [3:0] OP_SUBI    = 4'd8;
  localparam logic [3:0] OP_SYSCALL = 4'd9;

  localparam logic [27:0] SVC_EXIT = 28'd9;

  // Cycle costs.
  localparam logic [3:0] COST_NONE   = 4'd0;
  localparam logic [3:0] COST_LI     = 4'd3;
  localparam logic [3:0] COST_B      = 4'd4;
  localparam logic [3:0] COST_BRANCH = 4'd5;
  localparam logic [3:0] COST_LA     = 4'd5;
  localparam logic [3:0] COST_ALU    = 4'd6;
  localparam logic [3:0] COST_LB     = 4'd6;
  localparam logic [3:0] COST_SVC    = 4'd8;

  // Decoded item as it travels from the front to the back.
  typedef struct packed {
    logic            is_exec;
    logic            wr_ok;
    logic [3:0]      op;
    logic [RAW-1:0]  dst;
    logic [RAW-1:0]  src_a;
    logic [RAW-1:0]  src_b;
    logic [27:0]     imm;
    logic [11:0]     waddr;
    logic [7:0]      wbyte;
  } gpre_item_t;

  typedef struct packed {
    logic clearing;
    logic halted;
  } gpre_status_t;

  typedef struct packed {
    logic [27:0] pc;
    logic        halted;
    logic [3:0]  cost;
    logic        svc_valid;
    logic [27:0] svc_code;
    logic [31:0] svc_arg;
  } gpre_result_t;

endpackage

FILE: rtl/core/gpr_instruction_executor.sv
// Instruction executor for a ten-opcode register machine.
// Input beats (in_*): in_tuser selects the item kind, 0 for a data memory byte
// write and 1 for an instruction word fetched at the last reported pc offset.
// Every accepted beat gives exactly one result beat (out_*) carrying the next
// pc offset, the halted flag, the cycle cost and any system call report;
// out_tuser is high when the beat reports a system call.
// A front stage decodes each beat into a two-entry queue; the back end reads
// the register file, executes, and for a load-byte waits on the data memory.
// The back end finishes one item, including any load-byte read, before it fetches
// the next from the queue; execute waits while the output register holds a beat
// that the receiver has not taken.
// After reset the data memory is cleared one byte a cycle with in_tready low;
// registers, pc and the halted flag are zero at once.
// When the receiver stalls, the result is held in the output register; the
// front keeps taking beats until the queue and its own stage are full.
module gpr_instruction_executor
  import gpre_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // instr_word[31:0], data_addr[43:32], data_byte[51:44], zero[55:52]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pc_offset[27:0], halted[28], cost[32:29], service_code[60:33],
  // service_arg[92:61], zero[95:93]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // service_valid
  output logic                   out_tuser
);

`include "gpr_instruction_executor_macros.svh"

  gpre_status_t status;
  gpre_item_t   q_item, q_head;
  gpre_result_t res;
  logic         q_push, q_full, q_pop, q_empty;

  gpre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .status    (status),
    .q_push    (q_push),
    .q_item    (q_item),
    .q_full    (q_full)
  );

  gpre_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  gpre_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (res)
  );

  assign out_tdata = {3'd0, res.svc_arg, res.svc_code, res.cost, res.halted, res.pc};
  assign out_tuser = res.svc_valid;

`GPRE_ASSERT_NEVER(a_no_accept_while_clearing, status.clearing && in_tready, "beat accepted during memory clear")
`GPRE_ASSERT_NEVER(a_no_queue_overflow, q_push && q_full, "push into a full queue")
`GPRE_ASSERT_NEXT(a_halt_sticky, status.halted, status.halted, "halted flag cleared without reset")

endmodule

FILE: rtl/core/gpre_ram.sv
module gpre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/gpre_front.sv
module gpre_front
  import gpre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  gpre_status_t          status,
  output logic                  q_push,
  output gpre_item_t            q_item,
  input  logic                  q_full
);

  logic       stg_vld_r, stg_vld_nxt;
  gpre_item_t stg_item_r;
  gpre_item_t dec;
  logic       accept;
  logic [31:0] word;

  assign q_push    = stg_vld_r && !q_full;
  assign q_item    = stg_item_r;
  assign in_tready = !status.clearing && (!stg_vld_r || !q_full);
  assign accept    = in_tvalid && in_tready;
  assign word      = in_tdata[31:0];

  // A system call reads r0 for its argument, so port A is steered there.
  always_comb begin
    dec.is_exec = in_tuser;
    dec.op      = word[31:28];
    dec.dst     = word[27:23];
    dec.src_a   = (word[31:28] == OP_SYSCALL) ? RAW'(0) : word[27:23];
    dec.src_b   = word[22:18];
    dec.imm     = word[27:0];
    dec.waddr   = in_tdata[43:32];
    dec.wbyte   = in_tdata[51:44];
    dec.wr_ok   = (32'(in_tdata[43:32]) < DMEM_SPAN);
  end

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (accept) begin
      stg_vld_nxt = 1'b1;
    end else if (q_push) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
    if (accept) begin
      stg_item_r <= dec;
    end
  end

endmodule

FILE: rtl/core/gpre_queue.sv
module gpre_queue
  import gpre_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  gpre_item_t push_item,
  output logic       full,
  input  logic       pop,
  output gpre_item_t head,
  output logic       empty
);

  gpre_item_t       mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/core/gpre_back.sv
module gpre_back
  import gpre_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  gpre_item_t   q_head,
  output logic         q_pop,
  output gpre_status_t status,
  output logic         out_tvalid,
  input  logic         out_tready,
  output gpre_result_t out_result
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic [DAW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [27:0]    pc_r, pc_nxt;
  logic           halt_r, halt_nxt;
  logic [NREGS-1:0] vld_r, vld_nxt;
  logic           out_vld_r, out_vld_nxt;
  gpre_result_t   out_res_r, out_res_nxt;
  gpre_item_t     item_r;
  logic           va_r, vb_r;
  logic           lb_ok_r;

  logic           out_free, exec_fire, load_fire, fetch_go, clr_last;
  logic [31:0]    rfa_rdata, rfb_rdata, a_val, b_val, i18, i19;
  logic [31:0]    alu_val, ld_off, lb_val;
  logic           exec_we, ld_ok, is_lb;
  logic [27:0]    pc_exec;
  logic           halt_exec;
  logic [3:0]     cost_exec;
  logic           svc_v;
  logic [27:0]    svc_code;
  logic [31:0]    svc_arg;

  logic           rf_we;
  logic [RAW-1:0] rf_waddr;
  logic [31:0]    rf_wdata;
  logic           dm_we, dm_re;
  logic [DAW-1:0] dm_waddr, dm_raddr;
  logic [7:0]     dm_wdata, dm_rdata;

  assign out_free  = !out_vld_r || out_tready;
  assign fetch_go  = (state_r == ST_FETCH) && !q_empty;
  assign exec_fire = (state_r == ST_EXEC) && out_free;
  assign load_fire = (state_r == ST_LOAD) && out_free;
  assign clr_last  = (clr_cnt_r == DAW'(DATA_BYTES - 1));
  assign q_pop     = fetch_go;

  assign status.clearing = (state_r == ST_CLEAR);
  assign status.halted   = halt_r;
  assign out_tvalid      = out_vld_r;
  assign out_result      = out_res_r;

  // Duplicated register file gives two read ports.
  gpre_ram #(.WIDTH(32), .DEPTH(NREGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (fetch_go),
    .raddr (q_head.src_a),
    .rdata (rfa_rdata)
  );

  gpre_ram #(.WIDTH(32), .DEPTH(NREGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (fetch_go),
    .raddr (q_head.src_b),
    .rdata (rfb_rdata)
  );

  gpre_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  // A register never written since reset reads as zero.
  assign a_val = va_r ? rfa_rdata : 32'd0;
  assign b_val = vb_r ? rfb_rdata : 32'd0;
  assign i18   = {14'd0, item_r.imm[17:0]};
  assign i19   = {13'd0, item_r.imm[18:0]};

  assign ld_off = b_val + i18 - DATA_BASE;
  assign ld_ok  = (ld_off < DMEM_SPAN);
  assign lb_val = lb_ok_r ? {{24{dm_rdata[7]}}, dm_rdata} : 32'd0;

  always_comb begin
    pc_exec   = pc_r;
    halt_exec = halt_r;
    cost_exec = COST_NONE;
    svc_v     = 1'b0;
    svc_code  = '0;
    svc_arg   = '0;
    exec_we   = 1'b0;
    alu_val   = i19;
    is_lb     = 1'b0;
    if (item_r.is_exec && !halt_r) begin
      pc_exec = pc_r + 28'd1;
      unique case (item_r.op)
        OP_ADDI: begin
          alu_val   = b_val + i18;
          exec_we   = 1'b1;
          cost_exec = COST_ALU;
        end
        OP_B: begin
          pc_exec   = item_r.imm + 28'd1;
          cost_exec = COST_B;
        end
        OP_BEQZ: begin
          if (a_val == 32'd0) begin
            pc_exec   = 28'(i19) + 28'd1;
            cost_exec = COST_BRANCH;
          end
        end
        OP_BGE: begin
          if ($signed(a_val) >= $signed(b_val)) begin
            pc_exec   = 28'(i18) + 28'd1;
            cost_exec = COST_BRANCH;
          end
        end
        OP_BNE: begin
          if (a_val != b_val) begin
            pc_exec   = 28'(i18) + 28'd1;
            cost_exec = COST_BRANCH;
          end
        end
        OP_LA: begin
          alu_val   = DATA_BASE | i19;
          exec_we   = 1'b1;
          cost_exec = COST_LA;
        end
        OP_LB: begin
          is_lb = 1'b1;
        end
        OP_LI: begin
          alu_val   = i19;
          exec_we   = 1'b1;
          cost_exec = COST_LI;
        end
        OP_SUBI: begin
          alu_val   = b_val - i18;
          exec_we   = 1'b1;
          cost_exec = COST_ALU;
        end
        OP_SYSCALL: begin
          svc_v     = 1'b1;
          svc_code  = item_r.imm;
          svc_arg   = a_val;
          cost_exec = COST_SVC;
          if (item_r.imm == SVC_EXIT) begin
            halt_exec = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Register file write: ALU results at execute, loaded bytes in the load state.
  assign rf_we    = (exec_fire && exec_we) || load_fire;
  assign rf_waddr = item_r.dst;
  assign rf_wdata = (state_r == ST_LOAD) ? lb_val : alu_val;

  // The clearing pass owns the data memory write port until it finishes.
  assign dm_we    = status.clearing ||
                    (exec_fire && !item_r.is_exec && item_r.wr_ok);
  assign dm_waddr = status.clearing ? clr_cnt_r : DAW'(item_r.waddr);
  assign dm_wdata = status.clearing ? 8'd0 : item_r.wbyte;
  assign dm_re    = exec_fire && is_lb && ld_ok;
  assign dm_raddr = DAW'(ld_off);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pc_nxt      = pc_r;
    halt_nxt    = halt_r;
    vld_nxt     = vld_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_res_nxt = out_res_r;
    if (rf_we) begin
      vld_nxt[rf_waddr] = 1'b1;
    end
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + DAW'(1);
        if (clr_last) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (fetch_go) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          pc_nxt   = pc_exec;
          halt_nxt = halt_exec;
          if (is_lb) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt   = ST_FETCH;
            out_vld_nxt = 1'b1;
            out_res_nxt = '{pc: pc_exec, halted: halt_exec, cost: cost_exec,
                            svc_valid: svc_v, svc_code: svc_code, svc_arg: svc_arg};
          end
        end
      end
      ST_LOAD: begin
        if (load_fire) begin
          state_nxt   = ST_FETCH;
          out_vld_nxt = 1'b1;
          out_res_nxt = '{pc: pc_r, halted: halt_r, cost: COST_LB,
                          svc_valid: 1'b0, svc_code: 28'd0, svc_arg: 32'd0};
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      pc_r      <= '0;
      halt_r    <= 1'b0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pc_r      <= pc_nxt;
      halt_r    <= halt_nxt;
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    out_res_r <= out_res_nxt;
    if (fetch_go) begin
      item_r <= q_head;
      va_r   <= vld_r[q_head.src_a];
      vb_r   <= vld_r[q_head.src_b];
    end
    if (exec_fire) begin
      lb_ok_r <= ld_ok;
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import gpre_pkg::*;
();

  localparam int RANDOM_BEATS = 1700;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 500000;

  localparam logic [3:0] OP_SPARE_LO = 4'd10;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam logic [27:0] SVC_PRINT = 28'd1;

  typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_TOGGLE} sink_mode_t;

  typedef struct {
    logic        cmd;
    logic [31:0] word;
    logic [11:0] addr;
    logic [7:0]  wdata;
  } exec_beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Architectural state of the machine as the testbench expects it.
  logic [31:0] arch_regs [NREGS];
  logic [7:0]  data_mem [DATA_BYTES];
  logic [27:0] arch_pc;
  logic        arch_halted;

  exec_beat_t   stim_queue[$];
  gpre_result_t pending_results[$];
  exec_beat_t   cur_beat;

  int total_beats = 0;
  int n_accepted = 0;
  int n_exec = 0;
  int n_write = 0;
  int n_checked = 0;
  int n_svc = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int sink_left = 0;
  sink_mode_t sink_mode = SINK_FREE;

  gpr_instruction_executor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] enc_rr(logic [3:0] op, logic [4:0] ra, logic [4:0] rb,
                                         logic [17:0] imm);
    return {op, ra, rb, imm};
  endfunction

  function automatic logic [31:0] enc_ri(logic [3:0] op, logic [4:0] ra, logic [18:0] imm);
    return {op, ra, 4'b0000, imm};
  endfunction

  function automatic logic [31:0] enc_j(logic [3:0] op, logic [27:0] imm);
    return {op, imm};
  endfunction

  function automatic void push_exec(logic [31:0] word);
    exec_beat_t b;
    b.cmd = 1'b1;
    b.word = word;
    b.addr = 12'($urandom);
    b.wdata = 8'($urandom);
    stim_queue.push_back(b);
  endfunction

  function automatic void push_write(logic [11:0] addr, logic [7:0] wdata);
    exec_beat_t b;
    b.cmd = 1'b0;
    b.word = $urandom;
    b.addr = addr;
    b.wdata = wdata;
    stim_queue.push_back(b);
  endfunction

  // Mostly a handful of low registers, so that branches compare equal values often.
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
  endfunction

  function automatic gpre_result_t execute_item(exec_beat_t b);
    gpre_result_t r;
    logic [3:0]   op;
    logic [4:0]   ra;
    logic [4:0]   rb;
    logic [31:0]  i18;
    logic [31:0]  i19;
    logic [27:0]  i28;
    logic [31:0]  off;
    logic [27:0]  nxt;
    r = '0;
    if (!b.cmd) begin
      if (32'(b.addr) < DMEM_SPAN) data_mem[b.addr] = b.wdata;
    end else if (!arch_halted) begin
      op = b.word[31:28];
      ra = b.word[27:23];
      rb = b.word[22:18];
      i18 = {14'd0, b.word[17:0]};
      i19 = {13'd0, b.word[18:0]};
      i28 = b.word[27:0];
      nxt = arch_pc + 28'd1;
      case (op)
        OP_ADDI: begin
          arch_regs[ra] = arch_regs[rb] + i18;
          r.cost = COST_ALU;
        end
        OP_B: begin
          nxt = i28 + 28'd1;
          r.cost = COST_B;
        end
        OP_BEQZ: begin
          if (arch_regs[ra] == 32'd0) begin
            nxt = 28'(i19 + 32'd1);
            r.cost = COST_BRANCH;
          end
        end
        OP_BGE: begin
          if ($signed(arch_regs[ra]) >= $signed(arch_regs[rb])) begin
            nxt = 28'(i18 + 32'd1);
            r.cost = COST_BRANCH;
          end
        end
        OP_BNE: begin
          if (arch_regs[ra] != arch_regs[rb]) begin
            nxt = 28'(i18 + 32'd1);
            r.cost = COST_BRANCH;
          end
        end
        OP_LA: begin
          arch_regs[ra] = DATA_BASE + i19;
          r.cost = COST_LA;
        end
        OP_LB: begin
          // Offset from the memory base wraps, so addresses below the base miss too.
          off = arch_regs[rb] + i18 - DATA_BASE;
          if (off < DMEM_SPAN)
            arch_regs[ra] = {{24{data_mem[off[DAW-1:0]][7]}}, data_mem[off[DAW-1:0]]};
          else
            arch_regs[ra] = 32'd0;
          r.cost = COST_LB;
        end
        OP_LI: begin
          arch_regs[ra] = i19;
          r.cost = COST_LI;
        end
        OP_SUBI: begin
          arch_regs[ra] = arch_regs[rb] - i18;
          r.cost = COST_ALU;
        end
        OP_SYSCALL: begin
          r.svc_valid = 1'b1;
          r.svc_code = i28;
          r.svc_arg = arch_regs[0];
          if (i28 == SVC_EXIT) arch_halted = 1'b1;
          r.cost = COST_SVC;
        end
        default: begin
        end
      endcase
      arch_pc = nxt;
    end
    r.pc = arch_pc;
    r.halted = arch_halted;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(execute_item(cur_beat));
        n_accepted++;
        if (cur_beat.cmd) n_exec++;
        else n_write++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (stim_queue.size() != 0) begin
          cur_beat = stim_queue.pop_front();
          in_tdata <= {4'b0000, cur_beat.wdata, cur_beat.addr, cur_beat.word};
          in_tuser <= cur_beat.cmd;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) == 0) gap_left = 0;
            else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(6, 30);
            else gap_left = $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a stall mode held for a random stretch, then another.
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(16, 200);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_FREE:  out_tready <= 1'b1;
      SINK_LIGHT: out_tready <= ($urandom_range(0, 9) < 7);
      SINK_HEAVY: out_tready <= ($urandom_range(0, 9) < 2);
      default:    out_tready <= ~out_tready;
    endcase
  end

  always @(posedge clk) begin : monitor
    gpre_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat arrived with nothing outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("pc_offset", 32'(want.pc), 32'(out_tdata[27:0]));
        check_field("halted", 32'(want.halted), 32'(out_tdata[28]));
        check_field("cost", 32'(want.cost), 32'(out_tdata[32:29]));
        check_field("service_valid", 32'(want.svc_valid), 32'(out_tuser));
        check_field("service_code", 32'(want.svc_code), 32'(out_tdata[60:33]));
        check_field("service_arg", want.svc_arg, out_tdata[92:61]);
        n_checked++;
        if (out_tuser) n_svc++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[gpr_instruction_executor] ERROR");
      $finish;
    end
  end

  initial begin
    int          directed;
    int          sel;
    logic [4:0]  base;
    logic [31:0] w;
    logic [27:0] code;

    for (int i = 0; i < NREGS; i++) arch_regs[i] = 32'd0;
    for (int i = 0; i < DATA_BYTES; i++) data_mem[i] = 8'd0;
    arch_pc = 28'd0;
    arch_halted = 1'b0;

    // Directed part: field extremes, every opcode, loads at and past the memory edges.
    push_write(12'd0, 8'h80);
    push_write(12'd1, 8'h7f);
    push_write(12'hfff, 8'hff);
    push_write(12'd2, 8'h00);
    push_exec(enc_ri(OP_LI, 5'd1, 19'h7ffff));
    push_exec(enc_ri(OP_LA, 5'd2, 19'd0));
    push_exec(enc_rr(OP_LB, 5'd3, 5'd2, 18'd0));
    push_exec(enc_rr(OP_LB, 5'd4, 5'd2, 18'd1));
    push_exec(enc_rr(OP_LB, 5'd5, 5'd2, 18'hfff));
    push_exec(enc_rr(OP_LB, 5'd6, 5'd2, 18'h1000));
    push_exec(enc_rr(OP_LB, 5'd7, 5'd31, 18'd0));
    push_exec(enc_rr(OP_ADDI, 5'd8, 5'd31, 18'h3ffff));
    push_exec(enc_rr(OP_SUBI, 5'd9, 5'd31, 18'd1));
    push_exec(enc_rr(OP_ADDI, 5'd0, 5'd0, 18'd5));
    push_exec(enc_ri(OP_BEQZ, 5'd0, 19'h7ffff));
    push_exec(enc_ri(OP_BEQZ, 5'd10, 19'h7ffff));
    push_exec(enc_rr(OP_BGE, 5'd9, 5'd8, 18'h3ffff));
    push_exec(enc_rr(OP_BGE, 5'd8, 5'd9, 18'h3ffff));
    push_exec(enc_rr(OP_BGE, 5'd3, 5'd3, 18'd0));
    push_exec(enc_rr(OP_BNE, 5'd3, 5'd3, 18'd7));
    push_exec(enc_rr(OP_BNE, 5'd3, 5'd4, 18'd7));
    push_exec(enc_j(OP_B, 28'hffffffe));
    push_exec({OP_SPARE_LO, 28'h5a5a5a5});
    push_exec(enc_j(OP_B, 28'hfffffff));
    push_exec({OP_SPARE_HI, 28'hfffffff});
    push_exec(enc_j(OP_SYSCALL, SVC_PRINT));
    push_exec(enc_j(OP_SYSCALL, 28'hfffffff));
    directed = stim_queue.size();

    while (stim_queue.size() < directed + RANDOM_BEATS) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        push_write(($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 63)) : 12'($urandom),
                   8'($urandom));
      end else if (sel < 30) begin
        // Point a register into memory, then load through it.
        base = pick_reg();
        case ($urandom_range(0, 2))
          0:       push_exec(enc_ri(OP_LA, base, 19'($urandom_range(0, 63))));
          1:       push_exec(enc_ri(OP_LA, base, 19'($urandom_range(0, 4095))));
          default: push_exec(enc_ri(OP_LA, base, 19'($urandom)));
        endcase
        push_exec(enc_rr(OP_LB, pick_reg(), base,
                         ($urandom_range(0, 3) == 0) ? 18'($urandom) : 18'($urandom_range(0, 63))));
      end else if (sel < 40) begin
        push_exec(enc_ri(OP_LI, pick_reg(),
                         ($urandom_range(0, 1) == 0) ? 19'($urandom_range(0, 3)) : 19'($urandom)));
      end else if (sel < 60) begin
        push_exec(enc_rr(($urandom_range(0, 1) == 0) ? OP_ADDI : OP_SUBI, pick_reg(), pick_reg(),
                         ($urandom_range(0, 1) == 0) ? 18'($urandom_range(0, 7)) : 18'($urandom)));
      end else if (sel < 80) begin
        case ($urandom_range(0, 2))
          0:       push_exec(enc_ri(OP_BEQZ, pick_reg(), 19'($urandom)));
          1:       push_exec(enc_rr(OP_BGE, pick_reg(), pick_reg(), 18'($urandom)));
          default: push_exec(enc_rr(OP_BNE, pick_reg(), pick_reg(), 18'($urandom)));
        endcase
      end else if (sel < 85) begin
        push_exec(enc_j(OP_B, ($urandom_range(0, 7) == 0) ? 28'hfffffff : 28'($urandom)));
      end else if (sel < 90) begin
        code = ($urandom_range(0, 1) == 0) ? 28'($urandom_range(0, 15)) : 28'($urandom);
        if (code == SVC_EXIT) code = SVC_PRINT;
        push_exec(enc_j(OP_SYSCALL, code));
      end else begin
        // Arbitrary words, steering clear of the exit call, which would end the program early.
        w = $urandom;
        if (w[31:28] == OP_SYSCALL && w[27:0] == SVC_EXIT) w[0] = ~w[0];
        push_exec(w);
      end
    end

    // Exit, then beats that arrive while halted.
    push_exec(enc_j(OP_SYSCALL, SVC_EXIT));
    push_exec(enc_j(OP_SYSCALL, SVC_PRINT));
    push_exec(enc_rr(OP_ADDI, 5'd0, 5'd0, 18'd1));
    push_write(12'd0, 8'h55);
    push_exec(enc_rr(OP_LB, 5'd0, 5'd2, 18'd0));
    push_write(12'hfff, 8'h00);
    total_beats = stim_queue.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < total_beats || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats: %0d instruction words and %0d memory writes.",
             n_accepted, n_exec, n_write);
    $display("Checked %0d result beats, %0d of them service call reports.", n_checked, n_svc);
    if (fail_count == 0) begin
      $display("[gpr_instruction_executor] OK");
    end else begin
      $display("[gpr_instruction_executor] ERROR");
    end
    $finish;
  end

endmodule
